/* rtl/core/bgo_pkg.sv */
// Shared types and constants for the biased Gaussian opacity evaluator.
// No dependencies; imported by bgo_div, the top level and the testbench.
package bgo_pkg;

  // Input item kinds carried on s_tuser
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_EVAL  = 1'b1;

  // Q1.15 one and Q2.14 one
  localparam logic [16:0] Q15_ONE = 17'd32768;
  localparam logic [15:0] Q14_ONE = 16'd16384;

  // Entry 0 after reset
  localparam logic [17:0] RST_CENTER = 18'd32768;
  localparam logic [15:0] RST_HEIGHT = 16'd16384;
  localparam logic [16:0] RST_WIDTH  = 17'd6554;

  localparam logic [3:0] RST_ACTIVE = 4'd1;

  // Per-token sideband that rides along the pipeline
  typedef struct packed {
    logic [15:0] h;     // peak height
    logic [15:0] by;    // shape blend, clamped to 2.0
    logic        kill;  // token contributes zero
    logic        last;  // final token of an evaluation
    logic        zero;  // quotient forced to zero
  } side_t;

endpackage

/* rtl/core/bgo_div.sv */
// Pipelined restoring divider producing u15 = min(at * 2^15 / den, 1.0).
// One quotient bit per stage; depends on bgo_pkg.
module bgo_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_v,
  input  logic [19:0]       at,
  input  logic [18:0]       den,
  input  bgo_pkg::side_t    in_sd,
  output logic              out_v,
  output logic [15:0]       u15,
  output bgo_pkg::side_t    out_sd
);
  import bgo_pkg::*;

  localparam int NB = 15;

  logic          v   [NB+1];
  logic          sat [NB+1];
  logic [18:0]   rem [NB+1];
  logic [18:0]   dv  [NB+1];
  logic [14:0]   q   [NB+1];
  side_t         sd  [NB+1];

  // Entry stage: quotient at or above one saturates
  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sat[0] <= (at >= {1'b0, den});
      rem[0] <= (at >= {1'b0, den}) ? 19'd0 : at[18:0];
      dv[0]  <= den;
      q[0]   <= '0;
      sd[0]  <= in_sd;
    end
  end

  // One quotient bit per stage
  for (genvar k = 0; k < NB; k++) begin : g_bit
    logic [19:0] r2;
    logic        ge;

    assign r2 = {rem[k], 1'b0};
    assign ge = (r2 >= {1'b0, dv[k]});

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k+1] <= ge ? 19'(r2 - {1'b0, dv[k]}) : r2[18:0];
        q[k+1]   <= {q[k][13:0], ge};
        dv[k+1]  <= dv[k];
        sat[k+1] <= sat[k];
        sd[k+1]  <= sd[k];
      end
    end
  end

  // Select final quotient
  assign out_v  = v[NB];
  assign out_sd = sd[NB];
  assign u15    = sd[NB].zero ? 16'd0 : (sat[NB] ? Q15_ONE[15:0] : {1'b0, q[NB]});

endmodule

/* rtl/core/biased_gaussian_opacity_eval_unit.sv */
// Biased Gaussian opacity evaluator: bump table, issue sequencer, deep pipeline.
// Depends on bgo_pkg and bgo_div.
//
//  channel  dir  signals                         contents
//  s_*      in   s_tvalid s_tready s_tdata s_tuser  write entry or evaluate sample
//  m_*      out  m_tvalid m_tready m_tdata          opacity, one per evaluate item
//  cfg_*    in   cfg_wen cfg_wdata                  active_count
//
// An evaluate item issues N = max(1, min(active_count, MAX_BUMPS)) table entries,
// one per cycle while the output is not stalled, with s_tready low until the last
// entry has issued, so the next item is taken only after that. Its result passes
// through the pipeline, the 16-stage divider among it. A write item does not hold s_tready low.
// rst is synchronous; it restores entry 0 and active_count = 1.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
module biased_gaussian_opacity_eval_unit #(
  parameter int MAX_BUMPS       = 8,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // entry_index[2:0] center[20:3] peak_height[36:21] half_width[53:37]
  // skew[71:54] shape_blend[87:72] sample_pos[104:88], zero fill above
  input  logic [111:0] s_tdata,
  // action[0]
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // opacity[15:0]
  output logic [15:0]  m_tdata,
  input  logic         cfg_wen,
  input  logic [3:0]   cfg_wdata
);
  import bgo_pkg::*;

  localparam int IW   = (MAX_BUMPS > 1) ? $clog2(MAX_BUMPS) : 1;
  localparam int CW   = $clog2(MAX_BUMPS + 1);
  localparam int AW   = $clog2(EXP_TABLE_DEPTH);
  localparam int DM1  = EXP_TABLE_DEPTH - 1;
  localparam logic [63:0] Den2 = 64'(DM1) * 64'(DM1);
  localparam logic [63:0] Q31  = 64'd2147483648;

  // Exponential table, exp(-4 (k/(D-1))^2) in Q1.15
  logic [15:0] exp_rom [EXP_TABLE_DEPTH];
  for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] Y  = (64'(4 * k * k) << 31) / Den2;
    localparam logic [63:0] Z  = Y >> 6;
    localparam logic [63:0] T1 = ((Q31 * Z) >> 31) / 1;
    localparam logic [63:0] A1 = (Q31 >= T1) ? Q31 - T1 : 64'd0;
    localparam logic [63:0] T2 = ((T1 * Z) >> 31) / 2;
    localparam logic [63:0] A2 = A1 + T2;
    localparam logic [63:0] T3 = ((T2 * Z) >> 31) / 3;
    localparam logic [63:0] A3 = (A2 >= T3) ? A2 - T3 : 64'd0;
    localparam logic [63:0] T4 = ((T3 * Z) >> 31) / 4;
    localparam logic [63:0] A4 = A3 + T4;
    localparam logic [63:0] T5 = ((T4 * Z) >> 31) / 5;
    localparam logic [63:0] A5 = (A4 >= T5) ? A4 - T5 : 64'd0;
    localparam logic [63:0] T6 = ((T5 * Z) >> 31) / 6;
    localparam logic [63:0] A6 = A5 + T6;
    localparam logic [63:0] S1 = (A6 * A6) >> 31;
    localparam logic [63:0] S2 = (S1 * S1) >> 31;
    localparam logic [63:0] S3 = (S2 * S2) >> 31;
    localparam logic [63:0] S4 = (S3 * S3) >> 31;
    localparam logic [63:0] S5 = (S4 * S4) >> 31;
    localparam logic [63:0] S6 = (S5 * S5) >> 31;
    localparam logic [63:0] V  = (S6 + 64'd32768) >> 16;
    assign exp_rom[k] = V[15:0];
  end

  // Input field unpack
  logic        action;
  logic [2:0]  entry_index;
  logic [17:0] center;
  logic [15:0] peak_height;
  logic [16:0] half_width;
  logic [17:0] skew;
  logic [15:0] shape_blend;
  logic [16:0] sample_pos;

  assign action      = s_tuser;
  assign entry_index = s_tdata[2:0];
  assign center      = s_tdata[20:3];
  assign peak_height = s_tdata[36:21];
  assign half_width  = s_tdata[53:37];
  assign skew        = s_tdata[71:54];
  assign shape_blend = s_tdata[87:72];
  assign sample_pos  = s_tdata[104:88];

  // Global advance: freeze the sequencer and pipeline while a result waits
  logic en;
  assign en = !m_tvalid || m_tready;

  logic busy;
  logic s_acc;
  assign s_tready = en && !busy;
  assign s_acc    = s_tvalid && s_tready;

  // Configuration register
  logic [3:0] active_count;
  always_ff @(posedge clk) begin
    if (rst) begin
      active_count <= RST_ACTIVE;
    end else if (cfg_wen) begin
      active_count <= cfg_wdata;
    end
  end

  // Bump table
  logic [17:0] center_store [MAX_BUMPS];
  logic [15:0] height_store [MAX_BUMPS];
  logic [16:0] width_store  [MAX_BUMPS];
  logic [17:0] skew_store   [MAX_BUMPS];
  logic [15:0] blend_store  [MAX_BUMPS];

  logic          wr_en;
  logic [IW-1:0] wr_idx;
  assign wr_en  = s_acc && (action == ACT_WRITE) && (32'(entry_index) < MAX_BUMPS);
  assign wr_idx = IW'(entry_index);

  always_ff @(posedge clk) begin
    if (rst) begin
      center_store[0] <= RST_CENTER;
      height_store[0] <= RST_HEIGHT;
      width_store[0]  <= RST_WIDTH;
      skew_store[0]   <= '0;
      blend_store[0]  <= '0;
    end else if (wr_en) begin
      center_store[wr_idx] <= center;
      height_store[wr_idx] <= peak_height;
      width_store[wr_idx]  <= half_width;
      skew_store[wr_idx]   <= skew;
      blend_store[wr_idx]  <= shape_blend;
    end
  end

  // Issue sequencer: one table entry per cycle while the output is not stalled
  logic [CW-1:0] cnt, total;
  logic          empty;
  logic [16:0]   sample;
  logic [CW-1:0] n_act;
  logic          iss_last;

  assign n_act    = (32'(active_count) > MAX_BUMPS) ? CW'(MAX_BUMPS) : CW'(active_count);
  assign iss_last = (cnt == total - CW'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (s_acc && action == ACT_EVAL) begin
      busy <= 1'b1;
    end else if (en && busy && iss_last) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_acc && action == ACT_EVAL) begin
      cnt    <= '0;
      total  <= (n_act == '0) ? CW'(1) : n_act;
      empty  <= (n_act == '0);
      sample <= sample_pos;
    end else if (en && busy) begin
      cnt <= cnt + CW'(1);
    end
  end

  // Stage 1: table read
  logic          v1;
  logic [16:0]   smp1;
  logic [17:0]   c1, b1;
  logic [16:0]   w01;
  side_t         sd1;
  logic [IW-1:0] rd_idx;
  assign rd_idx = cnt[IW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= busy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      smp1    <= sample;
      c1      <= center_store[rd_idx];
      w01     <= width_store[rd_idx];
      b1      <= skew_store[rd_idx];
      sd1.h   <= height_store[rd_idx];
      sd1.by  <= (blend_store[rd_idx] > Q15_ONE[15:0]) ? Q15_ONE[15:0] : blend_store[rd_idx];
      sd1.kill <= empty;
      sd1.last <= iss_last;
      sd1.zero <= 1'b0;
    end
  end

  // Stage 2: offset from center
  logic               v2;
  logic signed [19:0] d2;
  logic [16:0]        w02;
  logic signed [17:0] b2;
  side_t              sd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2  <= $signed({3'b000, smp1}) - $signed({{2{c1[17]}}, c1});
      w02 <= w01;
      b2  <= $signed(b1);
      sd2 <= sd1;
    end
  end

  // Stage 3: range test, skew clamp, width floor
  logic               v3;
  logic signed [19:0] d3;
  logic signed [18:0] b3;
  logic [16:0]        w3;
  side_t              sd3;
  logic signed [19:0] w0s;
  logic               outside;
  logic signed [18:0] bcl;

  assign w0s     = $signed({3'b000, w02});
  assign outside = (d2 > w0s) || (d2 < -w0s);
  always_comb begin
    bcl = 19'(b2);
    if (20'(b2) > w0s) begin
      bcl = w0s[18:0];
    end else if (20'(b2) < -w0s) begin
      bcl = 19'(-w0s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3  <= d2;
      b3  <= bcl;
      w3  <= (w02 == '0) ? 17'd1 : w02;
      sd3 <= {sd2.h, sd2.by, sd2.kill || outside, sd2.last, sd2.zero};
    end
  end

  // Stage 4: warped offset and divisor
  logic               v4;
  logic [19:0]        at4;
  logic [18:0]        den4;
  side_t              sd4;
  logic signed [20:0] t;
  logic signed [19:0] den;

  assign t   = 21'(d3) - 21'(b3);
  assign den = (t > 0) ? ($signed({3'b000, w3}) - 20'(b3))
                       : ($signed({3'b000, w3}) + 20'(b3));

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      at4  <= (t < 0) ? 20'(-t) : 20'(t);
      den4 <= den[18:0];
      sd4  <= {sd3.h, sd3.by, sd3.kill, sd3.last, (t == 0) || (den <= 0)};
    end
  end

  // Divider
  logic        vd;
  logic [15:0] u15;
  side_t       sdd;

  bgo_div u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_v   (v4),
    .at     (at4),
    .den    ((sd4.zero) ? 19'd1 : den4),
    .in_sd  (sd4),
    .out_v  (vd),
    .u15    (u15),
    .out_sd (sdd)
  );

  // Stage 5: square and table index
  logic          v5;
  logic [15:0]   u2_5;
  logic [AW-1:0] idx5;
  side_t         sd5;
  logic [31:0]   usq, uix;

  assign usq = 32'(u15) * 32'(u15);
  assign uix = 32'(u15) * 32'(DM1) + 32'(Q14_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= vd;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u2_5 <= usq[30:15];
      idx5 <= uix[15 +: AW];
      sd5  <= sdd;
    end
  end

  // Stage 6: table lookup and parabola
  logic        v6;
  logic [15:0] gauss6, parab6;
  side_t       sd6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      gauss6 <= exp_rom[idx5];
      parab6 <= 16'(Q15_ONE - 17'(u2_5));
      sd6    <= sd5;
    end
  end

  // Stage 7: shape blend
  logic        v7;
  logic [15:0] h1_7;
  side_t       sd7;
  logic [32:0] blend_sum;

  always_comb begin
    if (sd6.by < Q14_ONE) begin
      blend_sum = 33'(32'(sd6.by) * 32'(parab6))
                + 33'(32'(Q14_ONE - sd6.by) * 32'(gauss6));
    end else begin
      blend_sum = 33'(32'(Q15_ONE[15:0] - sd6.by) * 32'(parab6))
                + 33'(32'(sd6.by - Q14_ONE) * 32'(Q15_ONE));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h1_7 <= blend_sum[29:14];
      sd7  <= sd6;
    end
  end

  // Stage 8: height scale
  logic        v8;
  logic [15:0] val8;
  logic        last8;
  logic [31:0] hprod;

  assign hprod = 32'(sd7.h) * 32'(h1_7);

  always_ff @(posedge clk) begin
    if (rst) begin
      v8 <= 1'b0;
    end else if (en) begin
      v8 <= v7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val8  <= sd7.kill ? 16'd0 : hprod[30:15];
      last8 <= sd7.last;
    end
  end

  // Running maximum and output register
  logic [15:0] best;
  logic [15:0] best_next;

  assign best_next = (val8 > best) ? val8 : best;

  always_ff @(posedge clk) begin
    if (rst) begin
      best <= '0;
    end else if (en && v8) begin
      best <= last8 ? 16'd0 : best_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en && v8 && last8) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v8 && last8) begin
      m_tdata <= (best_next > Q15_ONE[15:0]) ? Q15_ONE[15:0] : best_next;
    end
  end

endmodule

/* rtl/core/bgo_chk.sv */
// Port-level checks for the opacity evaluator, bound to the top level.
// Depends only on the top level's ports.
module bgo_chk (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         s_tuser,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [15:0]  m_tdata
);

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // Opacity never exceeds 1.0
  a_sat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata <= 16'd32768)
    else $error("opacity above 1.0");

  // No result right after reset
  a_rst: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result after reset");

  // Sequencer is busy the cycle after an evaluate item
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser |=> !s_tready)
    else $error("input taken while issuing entries");

endmodule

bind biased_gaussian_opacity_eval_unit bgo_chk u_bgo_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* verif/biased_gaussian_opacity_eval_unit_tb.sv */
// Self-checking testbench for biased_gaussian_opacity_eval_unit: streams bump
// writes and evaluate items, predicts each opacity and compares it.
// Depends on bgo_pkg and the RTL of the evaluator.
module biased_gaussian_opacity_eval_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bgo_pkg::*;

  localparam int NUM_BUMPS = 8;
  localparam int ROM_DEPTH = 256;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic        act;
    logic [2:0]  idx;
    logic [17:0] ctr;
    logic [15:0] hgt;
    logic [16:0] hw;
    logic [17:0] skw;
    logic [15:0] bl;
    logic [16:0] smp;
  } bump_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [15:0]  m_tdata;
  logic         cfg_wen = 1'b0;
  logic [3:0]   cfg_wdata = '0;

  // Predictor state
  logic signed [17:0] ctr_tab[NUM_BUMPS];
  logic [15:0]        hgt_tab[NUM_BUMPS];
  logic [16:0]        wid_tab[NUM_BUMPS];
  logic signed [17:0] skw_tab[NUM_BUMPS];
  logic [15:0]        bl_tab[NUM_BUMPS];
  logic [3:0]         active_n;
  logic [15:0]        gauss_rom[ROM_DEPTH];

  bump_item_t  pend_q[$];
  logic [15:0] opacity_q[$];
  int          errors = 0;
  int          src_gap = 0;
  int          snk_stall = 0;
  bit          src_quiet = 0;
  bit          snk_quiet = 0;

  biased_gaussian_opacity_eval_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end

  // exp(-4u^2) table: Taylor series in Q31, squared six times
  function automatic void build_gauss_rom();
    longint unsigned den2, y, z, acc, term;
    den2 = (ROM_DEPTH - 1) * (ROM_DEPTH - 1);
    for (int k = 0; k < ROM_DEPTH; k++) begin
      y = ((64'd4 * k * k) << 31) / den2;
      z = y >> 6;
      acc = 64'd2147483648;
      term = 64'd2147483648;
      for (int i = 1; i <= 6; i++) begin
        term = ((term * z) >> 31) / i;
        if (i % 2 == 1) acc = (acc >= term) ? acc - term : 0;
        else acc = acc + term;
      end
      for (int i = 0; i < 6; i++) acc = (acc * acc) >> 31;
      gauss_rom[k] = 16'((acc + 32768) >> 16);
    end
  endfunction

  // Value of one bump at a sample position
  function automatic longint bump_level(int e, longint smp);
    longint c, w0, b, d, w, t, den, at, u15, u2, idx, p, h1, by;
    c = ctr_tab[e];
    w0 = wid_tab[e];
    b = skw_tab[e];
    by = bl_tab[e];
    d = smp - c;
    if (d > w0 || d < -w0) return 0;
    if (b > w0) b = w0;
    if (b < -w0) b = -w0;
    w = (w0 == 0) ? 1 : w0;
    t = d - b;
    den = (t > 0) ? (w - b) : (w + b);
    at = (t < 0) ? -t : t;
    if (t == 0 || den <= 0) u15 = 0;
    else u15 = (at <<< 15) / den;
    if (u15 > 32768) u15 = 32768;
    u2 = (u15 * u15) >>> 15;
    idx = (u15 * (ROM_DEPTH - 1) + 16384) >>> 15;
    if (idx >= ROM_DEPTH) idx = ROM_DEPTH - 1;
    p = 32768 - u2;
    if (by > 32768) by = 32768;
    if (by < 16384) h1 = (by * p + (16384 - by) * longint'(gauss_rom[idx])) >>> 14;
    else h1 = ((32768 - by) * p + (by - 16384) * 32768) >>> 14;
    return (longint'(hgt_tab[e]) * h1) >>> 15;
  endfunction

  // Update the table or queue the expected opacity, then hand to the driver
  task automatic send_item(bump_item_t it);
    longint best, v;
    int n;
    if (it.act == ACT_WRITE) begin
      ctr_tab[it.idx] = it.ctr;
      hgt_tab[it.idx] = it.hgt;
      wid_tab[it.idx] = it.hw;
      skw_tab[it.idx] = it.skw;
      bl_tab[it.idx] = it.bl;
    end else begin
      n = (active_n > NUM_BUMPS) ? NUM_BUMPS : active_n;
      best = 0;
      for (int e = 0; e < n; e++) begin
        v = bump_level(e, it.smp);
        if (v > best) best = v;
      end
      if (best > 32768) best = 32768;
      opacity_q.push_back(16'(best));
    end
    pend_q.push_back(it);
  endtask

  task automatic send_write(int e, int c, int h, int w, int s, int bl);
    bump_item_t it;
    it = '{ACT_WRITE, 3'(e), 18'(c), 16'(h), 17'(w), 18'(s), 16'(bl), 17'($urandom)};
    send_item(it);
  endtask

  task automatic send_eval(int smp);
    bump_item_t it;
    it = '{ACT_EVAL, 3'($urandom), 18'($urandom), 16'($urandom), 17'($urandom),
           18'($urandom), 16'($urandom), 17'(smp)};
    send_item(it);
  endtask

  // Wait until the block is idle with nothing left outstanding
  task automatic drain();
    while (pend_q.size() != 0 || s_tvalid || opacity_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_active(int v);
    @(posedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= 4'(v);
    @(posedge clk);
    cfg_wen <= 1'b0;
    active_n = 4'(v);
  endtask

  // Random write, mostly compact bumps inside the unit range
  task automatic rand_write();
    int c, h, w, s, bl;
    if ($urandom_range(0, 7) == 0) begin
      send_write($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      c = $urandom_range(0, 131071);
      w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 131071) : $urandom_range(0, 20000);
      s = ($urandom_range(0, 5) == 0) ? int'($urandom_range(0, 262143)) - 131072
                                      : int'($urandom_range(0, 2 * w)) - w;
      h = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 32768);
      bl = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 32768);
      send_write($urandom_range(0, 7), c, h, w, s, bl);
    end
  endtask

  // Random evaluate, mostly aimed inside an active bump
  task automatic rand_eval();
    int n, e, smp;
    n = (active_n > NUM_BUMPS) ? NUM_BUMPS : active_n;
    if (n == 0 || $urandom_range(0, 5) == 0) begin
      smp = $urandom_range(0, 131071);
    end else begin
      e = $urandom_range(0, n - 1);
      smp = int'(ctr_tab[e]) + int'($urandom_range(0, 2 * wid_tab[e] + 4)) - int'(wid_tab[e]) - 2;
      if (smp < 0) smp = 0;
      if (smp > 131071) smp = 131071;
    end
    send_eval(smp);
  endtask

  // Stimulus
  initial begin
    int actives[10];
    actives = '{15, 3, 8, 1, 0, 5, 9, 8, 2, 7};
    build_gauss_rom();
    for (int e = 0; e < NUM_BUMPS; e++) begin
      ctr_tab[e] = '0; hgt_tab[e] = '0; wid_tab[e] = '0; skw_tab[e] = '0; bl_tab[e] = '0;
    end
    ctr_tab[0] = RST_CENTER;
    hgt_tab[0] = RST_HEIGHT;
    wid_tab[0] = RST_WIDTH;
    active_n = RST_ACTIVE;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Entry 0 as left by reset
    send_eval(32768);
    send_eval(32768 + 6554);
    send_eval(32768 + 6555);
    send_eval(0);
    send_eval(131071);
    drain();
    // No active entries
    write_active(0);
    send_eval(32768);
    // Zero width, skew beyond width, blend above 2, height above 1, corner values
    send_write(0, 0, 32768, 0, 0, 0);
    send_write(1, -131072, 65535, 131071, 131071, 65535);
    send_write(2, 131071, 0, 131071, -131072, 16384);
    send_write(3, 65536, 40000, 20000, 5000, 32768);
    send_write(4, 50000, 32768, 30000, -10000, 8000);
    send_write(5, 80000, 20000, 1, 1, 24000);
    send_write(6, 10000, 32768, 65536, 0, 0);
    send_write(7, 100000, 30000, 40000, -40000, 16000);
    drain();
    write_active(8);
    send_eval(0);
    send_eval(1);
    send_eval(65536);
    send_eval(80000);
    send_eval(80001);
    send_eval(45000);
    send_eval(131071);
    send_eval(100000);

    // Random phases, each under its own active count
    foreach (actives[p]) begin
      drain();
      write_active(actives[p]);
      repeat (88) begin
        if ($urandom_range(0, 2) == 0) rand_write();
        else rand_eval();
      end
    end
    drain();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Driver: present the next item after a random gap, hold while stalled
  always @(posedge clk) begin
    bump_item_t it;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!(s_tvalid && !s_tready)) begin
      if (src_gap != 0) begin
        s_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pend_q.size() != 0) begin
        it = pend_q.pop_front();
        s_tdata <= {7'd0, it.smp, it.bl, it.skw, it.hw, it.hgt, it.ctr, it.idx};
        s_tuser <= it.act;
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 19) == 0) src_quiet = ~src_quiet;
        src_gap <= src_quiet ? 0 : $urandom_range(0, 15);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: check each opacity against the oldest expectation, stall at random
  always @(posedge clk) begin
    int st;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      if (opacity_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected opacity item, actual %0d", $time, m_tdata);
      end else if (opacity_q[0] !== m_tdata) begin
        errors++;
        $display("%0t: opacity mismatch, expected %0d actual %0d",
                 $time, opacity_q[0], m_tdata);
        void'(opacity_q.pop_front());
      end else begin
        void'(opacity_q.pop_front());
      end
      if ($urandom_range(0, 19) == 0) snk_quiet = ~snk_quiet;
      st = snk_quiet ? 0 : $urandom_range(0, 15);
      if (st != 0) m_tready <= 1'b0;
      snk_stall <= st;
    end else if (snk_stall > 1) begin
      m_tready <= 1'b0;
      snk_stall <= snk_stall - 1;
    end else begin
      m_tready <= 1'b1;
      snk_stall <= 0;
    end
  end

endmodule

/* biased_gaussian_opacity_eval_unit.f */
rtl/core/bgo_pkg.sv
rtl/core/bgo_div.sv
rtl/core/biased_gaussian_opacity_eval_unit.sv
rtl/core/bgo_chk.sv
verif/biased_gaussian_opacity_eval_unit_tb.sv
